FILE: rtl/cstd_pkg.sv
// ----------------------------------------------------------------------------
// cstd_pkg
// Shared types and constants of the CAN signal table decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cstd_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;
	localparam int MAX_SEARCH        = 16;

	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_DECODE = 1'b1;

	// one signal definition as held in the table
	typedef struct packed {
		logic [28:0] frame_id;
		logic [31:0] offset;
		logic [31:0] scale;
		logic [2:0]  last_byte;
		logic [2:0]  first_byte;
	} entry_t;

	// input beat, first field in the highest bits
	typedef struct packed {
		logic [3:0]  pad;
		logic [63:0] frame_payload;
		logic [28:0] frame_id;
		logic [2:0]  entry_last_byte;
		logic [2:0]  entry_first_byte;
		logic [31:0] entry_scale;
		logic [31:0] entry_offset;
		logic [28:0] entry_frame_id;
		logic [3:0]  entry_slot;
	} in_beat_t;

	// output beat, first field in the highest bits
	typedef struct packed {
		logic [3:0]  pad;
		logic [63:0] eng_value;
		logic [63:0] raw_value;
		logic [3:0]  signal_slot;
	} out_beat_t;

	// step strobes for the arithmetic unit
	typedef struct packed {
		logic load;
		logic mul_lo;
		logic mul_hi;
		logic sum;
		logic add;
	} phys_ctrl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_MATCH,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_SUM,
		ST_ADD,
		ST_EMIT,
		ST_FLUSH
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/cstd_tbl_mem.sv
// ----------------------------------------------------------------------------
// cstd_tbl_mem
// Signal definition table: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cstd_tbl_mem #(
	parameter int DEPTH = cstd_pkg::TABLE_ENTRIES_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire                     clk,
	input  wire                     wr_en,
	input  wire  [AW-1:0]           wr_addr,
	input  cstd_pkg::entry_t        wr_data,
	input  wire                     rd_en,
	input  wire  [AW-1:0]           rd_addr,
	output cstd_pkg::entry_t        rd_data
);

	cstd_pkg::entry_t mem_q [DEPTH];
	cstd_pkg::entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

FILE: rtl/cstd_phys.sv
// ----------------------------------------------------------------------------
// cstd_phys
// Physical value unit: offset + scale * raw * 2^16, saturated to 64 bits.
// One shared 32x32 multiplier, one step per strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module cstd_phys (
	input  wire                     clk,
	input  cstd_pkg::phys_ctrl_t    ctrl,
	input  wire  [31:0]             scale,
	input  wire  [31:0]             offset,
	input  wire  [63:0]             raw,
	output logic [63:0]             phys_value,
	output logic                    saturated
);

	logic        neg_q;
	logic [31:0] mag_q;
	logic [31:0] off_q;
	logic [63:0] lo_q;
	logic [63:0] hi_q;
	logic [47:0] p_q;
	logic        ovf_q;
	logic [63:0] phys_q;
	logic        sat_q;

	logic [31:0]        mul_op;
	logic [63:0]        prod;
	logic [64:0]        p_full;
	logic [65:0]        q_ext;
	logic signed [65:0] q_signed;
	logic signed [65:0] sum_v;

	assign mul_op = ctrl.mul_hi ? raw[63:32] : raw[31:0];
	assign prod   = 64'(mag_q) * 64'(mul_op);

	// product below 2^48 only if the high partial is below 2^16 and the sum carries no further
	assign p_full = 65'({hi_q[15:0], 32'h0}) + 65'(lo_q);

	assign q_ext    = {2'b00, p_q, 16'h0};
	assign q_signed = neg_q ? -$signed(q_ext) : $signed(q_ext);
	assign sum_v    = q_signed + $signed({{34{off_q[31]}}, off_q});

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			neg_q <= scale[31];
			mag_q <= scale[31] ? (~scale + 32'd1) : scale;
			off_q <= offset;
		end
		if (ctrl.mul_lo) begin
			lo_q <= prod;
		end
		if (ctrl.mul_hi) begin
			hi_q <= prod;
		end
		if (ctrl.sum) begin
			p_q   <= p_full[47:0];
			ovf_q <= (|hi_q[63:16]) | (|p_full[64:48]);
		end
		if (ctrl.add) begin
			if (ovf_q) begin
				phys_q <= neg_q ? {1'b1, 63'h0} : {1'b0, {63{1'b1}}};
				sat_q  <= 1'b1;
			end else if (!sum_v[65] && (sum_v[64] || sum_v[63])) begin
				phys_q <= {1'b0, {63{1'b1}}};
				sat_q  <= 1'b1;
			end else if (sum_v[65] && !(sum_v[64] && sum_v[63])) begin
				phys_q <= {1'b1, 63'h0};
				sat_q  <= 1'b1;
			end else begin
				phys_q <= sum_v[63:0];
				sat_q  <= 1'b0;
			end
		end
	end

	assign phys_value = phys_q;
	assign saturated  = sat_q;

endmodule

`default_nettype wire

FILE: rtl/can_signal_table_decoder_top.sv
// ----------------------------------------------------------------------------
// can_signal_table_decoder_top
// Decodes CAN frames against a table of signal definitions held in memory.
// ----------------------------------------------------------------------------
//
// channel   direction  beat contents
// s_*       in         tuser: action; tdata: entry fields, frame id, payload
// m_*       out        tdata: slot, raw, physical; tuser: saturated; tlast: last
// cfg_*     in         active entry count
//
// table writes and frames are taken in idle; each searched entry is read, then
// compared; a match steps through multiply low, multiply high, sum, add, emit;
// then a flush; the single table read port and shared multiplier set this order
// reset clears the control state and the entry count; table entries stay
// undefined until written
// a stalled output holds one result in the output register and one pending,
// and the next match waits in the emit state until one of them moves
// ----------------------------------------------------------------------------
`default_nettype none

module can_signal_table_decoder_top #(
	parameter int TABLE_ENTRIES = cstd_pkg::TABLE_ENTRIES_DEF
) (
	input  wire          clk,
	input  wire          arst_n,

	input  wire          s_tvalid,
	output logic         s_tready,
	// slot, entry frame id, offset, scale, first byte, last byte, frame id,
	// payload, zero pad
	input  wire  [199:0] s_tdata,
	// action
	input  wire  [0:0]   s_tuser,

	output logic         m_tvalid,
	input  wire          m_tready,
	// signal slot, raw value, physical value, zero pad
	output logic [135:0] m_tdata,
	// saturated
	output logic [0:0]   m_tuser,
	output logic         m_tlast,

	input  wire          cfg_valid,
	output logic         cfg_ready,
	input  wire  [4:0]   cfg_data
);

	localparam int AW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int LIM = (TABLE_ENTRIES < cstd_pkg::MAX_SEARCH) ?
		TABLE_ENTRIES : cstd_pkg::MAX_SEARCH;

	cstd_pkg::state_t     state_q, state_d;
	cstd_pkg::in_beat_t   in_beat;
	cstd_pkg::entry_t     wr_entry, rd_entry;
	cstd_pkg::phys_ctrl_t pctrl;
	cstd_pkg::out_beat_t  out_q;

	logic [4:0]  cfg_q;
	logic [4:0]  count;
	logic [4:0]  count_q;
	logic [4:0]  idx_q;
	logic [28:0] fid_q;
	logic [63:0] payload_q;
	logic [63:0] raw_q;
	logic        pend_q;
	logic [3:0]  pend_slot_q;
	logic [63:0] pend_raw_q;
	logic [63:0] pend_phys_q;
	logic        pend_sat_q;
	logic        out_sat_q;
	logic        out_last_q;
	logic        m_tvalid_q;

	logic        s_acc;
	logic        tbl_we;
	logic        tbl_re;
	logic        latch_frame;
	logic        idx_inc;
	logic        raw_load;
	logic        pend_load;
	logic        pend_clr;
	logic        out_load;
	logic        out_free;
	logic        at_end;
	logic        hit;
	logic        slot_ok;
	logic [63:0] phys_value;
	logic        phys_sat;
	logic [63:0] shifted;
	logic [2:0]  span;
	logic [63:0] raw_next;

	assign in_beat   = cstd_pkg::in_beat_t'(s_tdata);
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign count     = (cfg_q > 5'(LIM)) ? 5'(LIM) : cfg_q;
	assign slot_ok   = (32'(in_beat.entry_slot) < 32'(TABLE_ENTRIES));
	assign tbl_we    = s_acc && (s_tuser[0] == cstd_pkg::ACT_WRITE) && slot_ok;

	assign wr_entry.frame_id   = in_beat.entry_frame_id;
	assign wr_entry.offset     = in_beat.entry_offset;
	assign wr_entry.scale      = in_beat.entry_scale;
	assign wr_entry.last_byte  = in_beat.entry_last_byte;
	assign wr_entry.first_byte = in_beat.entry_first_byte;

	cstd_tbl_mem #(
		.DEPTH (TABLE_ENTRIES),
		.AW    (AW)
	) u_tbl (
		.clk     (clk),
		.wr_en   (tbl_we),
		.wr_addr (AW'(in_beat.entry_slot)),
		.wr_data (wr_entry),
		.rd_en   (tbl_re),
		.rd_addr (AW'(idx_q)),
		.rd_data (rd_entry)
	);

	cstd_phys u_phys (
		.clk        (clk),
		.ctrl       (pctrl),
		.scale      (rd_entry.scale),
		.offset     (rd_entry.offset),
		.raw        (raw_q),
		.phys_value (phys_value),
		.saturated  (phys_sat)
	);

	// byte field extraction
	assign shifted  = payload_q >> {rd_entry.first_byte, 3'b000};
	assign span     = rd_entry.last_byte - rd_entry.first_byte;
	assign raw_next = (rd_entry.last_byte < rd_entry.first_byte) ? 64'h0 :
		(shifted & ({64{1'b1}} >> {3'd7 - span, 3'b000}));

	assign hit      = (rd_entry.frame_id == fid_q);
	assign at_end   = ((idx_q + 5'd1) == count_q);
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		tbl_re      = 1'b0;
		latch_frame = 1'b0;
		idx_inc     = 1'b0;
		raw_load    = 1'b0;
		pend_load   = 1'b0;
		pend_clr    = 1'b0;
		out_load    = 1'b0;
		pctrl       = '0;
		case (state_q)
			cstd_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tuser[0] == cstd_pkg::ACT_DECODE) begin
					latch_frame = 1'b1;
					if (count != 5'd0) begin
						state_d = cstd_pkg::ST_READ;
					end
				end
			end
			cstd_pkg::ST_READ: begin
				tbl_re  = 1'b1;
				state_d = cstd_pkg::ST_MATCH;
			end
			cstd_pkg::ST_MATCH: begin
				if (hit) begin
					pctrl.load = 1'b1;
					raw_load   = 1'b1;
					state_d    = cstd_pkg::ST_MUL_LO;
				end else begin
					idx_inc = 1'b1;
					state_d = at_end ? cstd_pkg::ST_FLUSH : cstd_pkg::ST_READ;
				end
			end
			cstd_pkg::ST_MUL_LO: begin
				pctrl.mul_lo = 1'b1;
				state_d      = cstd_pkg::ST_MUL_HI;
			end
			cstd_pkg::ST_MUL_HI: begin
				pctrl.mul_hi = 1'b1;
				state_d      = cstd_pkg::ST_SUM;
			end
			cstd_pkg::ST_SUM: begin
				pctrl.sum = 1'b1;
				state_d   = cstd_pkg::ST_ADD;
			end
			cstd_pkg::ST_ADD: begin
				pctrl.add = 1'b1;
				state_d   = cstd_pkg::ST_EMIT;
			end
			cstd_pkg::ST_EMIT: begin
				// older result leaves only when a newer one proves it is not last
				if (!pend_q || out_free) begin
					out_load  = pend_q;
					pend_load = 1'b1;
					idx_inc   = 1'b1;
					state_d   = at_end ? cstd_pkg::ST_FLUSH : cstd_pkg::ST_READ;
				end
			end
			cstd_pkg::ST_FLUSH: begin
				if (!pend_q) begin
					state_d = cstd_pkg::ST_IDLE;
				end else if (out_free) begin
					out_load = 1'b1;
					pend_clr = 1'b1;
					state_d  = cstd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cstd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= cstd_pkg::ST_IDLE;
			cfg_q      <= 5'd0;
			idx_q      <= 5'd0;
			pend_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				cfg_q <= cfg_data;
			end
			if (latch_frame) begin
				idx_q <= 5'd0;
			end else if (idx_inc) begin
				idx_q <= idx_q + 5'd1;
			end
			if (pend_load) begin
				pend_q <= 1'b1;
			end else if (pend_clr) begin
				pend_q <= 1'b0;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (latch_frame) begin
			fid_q     <= in_beat.frame_id;
			payload_q <= in_beat.frame_payload;
			count_q   <= count;
		end
		if (raw_load) begin
			raw_q <= raw_next;
		end
		if (out_load) begin
			out_q.pad         <= 4'h0;
			out_q.signal_slot <= pend_slot_q;
			out_q.raw_value   <= pend_raw_q;
			out_q.eng_value   <= pend_phys_q;
			out_sat_q         <= pend_sat_q;
			out_last_q        <= (state_q == cstd_pkg::ST_FLUSH);
		end
		if (pend_load) begin
			pend_slot_q <= idx_q[3:0];
			pend_raw_q  <= raw_q;
			pend_phys_q <= phys_value;
			pend_sat_q  <= phys_sat;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;
	assign m_tuser  = out_sat_q;
	assign m_tlast  = out_last_q;

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != cstd_pkg::ST_IDLE) |-> !tbl_we)
		else $error("table written while a frame is in work");

	a_pend_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cstd_pkg::ST_IDLE) |-> !pend_q)
		else $error("pending result left behind at end of frame");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cstd_pkg::ST_READ || state_q == cstd_pkg::ST_MATCH)
		|-> (idx_q < count_q))
		else $error("search index beyond active entries");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && state_q == cstd_pkg::ST_FLUSH) |=> !pend_q)
		else $error("pending result kept after last beat");

endmodule

`default_nettype wire
